@@ rtl/npf_pkg.sv @@
// ----------------------------------------------------------------------------
// npf_pkg: shared types and constants for the normalized path FNV-1a hasher
// Holds the hash constants, the slash counter sizing and the queue entry
// format that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package npf_pkg;

  // Longest slash run that is counted; longer runs saturate here.
  localparam int unsigned MAX_PATH_LEN = 4096;
  localparam int unsigned PEND_W       = $clog2(MAX_PATH_LEN + 1);

  // FNV-1a 64 constants. The prime is 2^40 + 0x1B3, so the multiply is a
  // shift plus a narrow product.
  localparam logic [63:0] FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;
  localparam int unsigned PRIME_SHIFT = 40;
  localparam int unsigned PRIME_LO_W  = 9;
  localparam logic [PRIME_LO_W-1:0] PRIME_LO = 9'h1B3;

  localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
  localparam logic [7:0] BYTE_SLASH     = 8'h2F;
  localparam logic [7:0] UPPER_FIRST    = 8'h41;
  localparam logic [7:0] UPPER_LAST     = 8'h5A;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SLASH,
    KIND_CHAR
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } entry_t;

endpackage

@@ rtl/npf_front.sv @@
// ----------------------------------------------------------------------------
// npf_front: input stage of the normalized path FNV-1a hasher
// Accepts raw path bytes, normalizes them and classifies each into a
// queue entry. Transactions that carry neither a byte nor an end mark are
// dropped here.
// ----------------------------------------------------------------------------
module npf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      path_byte_i,
  input  logic            has_byte_i,
  input  logic            last_i,
  input  logic            queue_full_i,
  output logic            push_o,
  output npf_pkg::entry_t push_entry_o
);

  logic            stage_valid_q, stage_valid_d;
  npf_pkg::entry_t stage_q, stage_d;
  logic            accept;
  logic [7:0]      norm_byte;
  npf_pkg::entry_t classified;

  // Backslash becomes slash, ASCII upper case becomes lower case.
  always_comb begin
    norm_byte = path_byte_i;
    if (path_byte_i == npf_pkg::BYTE_BACKSLASH) begin
      norm_byte = npf_pkg::BYTE_SLASH;
    end else if (path_byte_i >= npf_pkg::UPPER_FIRST &&
                 path_byte_i <= npf_pkg::UPPER_LAST) begin
      norm_byte = path_byte_i + npf_pkg::CASE_OFFSET;
    end
  end

  always_comb begin
    classified.data = norm_byte;
    classified.last = last_i;
    if (!has_byte_i) begin
      classified.kind = npf_pkg::KIND_NONE;
    end else if (norm_byte == npf_pkg::BYTE_SLASH) begin
      classified.kind = npf_pkg::KIND_SLASH;
    end else begin
      classified.kind = npf_pkg::KIND_CHAR;
    end
  end

  assign push_o       = stage_valid_q && !queue_full_i;
  assign push_entry_o = stage_q;
  assign in_stall_o   = stage_valid_q && queue_full_i;
  assign accept       = in_valid_i && !in_stall_o;

  always_comb begin
    stage_valid_d = stage_valid_q && !push_o;
    stage_d       = stage_q;
    if (accept && (has_byte_i || last_i)) begin
      stage_valid_d = 1'b1;
      stage_d       = classified;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

endmodule

@@ rtl/npf_queue.sv @@
// ----------------------------------------------------------------------------
// npf_queue: entry queue between front end and back end
// A small circular buffer that lets either side stall without holding up
// the other until it runs full or empty.
// ----------------------------------------------------------------------------
module npf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  npf_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output npf_pkg::entry_t head_entry_o
);

  npf_pkg::entry_t                slots_q [npf_pkg::QUEUE_DEPTH];
  logic [npf_pkg::QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [npf_pkg::QUEUE_CW-1:0]   count_q, count_d;
  logic                           do_push, do_pop;

  assign full_o       = (count_q == npf_pkg::QUEUE_CW'(npf_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + npf_pkg::QUEUE_CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - npf_pkg::QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + npf_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + npf_pkg::QUEUE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ rtl/npf_back.sv @@
// ----------------------------------------------------------------------------
// npf_back: hashing engine of the normalized path FNV-1a hasher
// Applies one FNV-1a round per cycle unless a result waits on a stall;
// counts slash runs, folds them in one round per cycle when a byte follows.
// ----------------------------------------------------------------------------
module npf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  npf_pkg::entry_t head_entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [63:0]     hash_value_o
);

  logic [63:0]                hash_q, hash_d;
  logic [npf_pkg::PEND_W-1:0] pend_q, pend_d, pend_inc, pend_step;
  logic                       seen_q, seen_d, seen_step;
  logic                       out_valid_q, out_valid_d;
  logic [63:0]                out_hash_q, out_hash_d;
  logic                       is_slash, is_char, flush_slash, out_free;
  logic [7:0]                 fold_byte;
  logic [63:0]                fold_x, fold_out, hash_step, final_hash;
  logic [63+npf_pkg::PRIME_LO_W:0] lo_prod;

  assign is_slash    = (head_entry_i.kind == npf_pkg::KIND_SLASH);
  assign is_char     = (head_entry_i.kind == npf_pkg::KIND_CHAR);
  assign flush_slash = is_char && (pend_q != '0);
  assign out_free    = !out_valid_q || !out_stall_i;

  // A single round unit; its byte is a held slash or the current character.
  assign fold_byte = (is_char && !flush_slash) ? head_entry_i.data : npf_pkg::BYTE_SLASH;
  assign fold_x    = hash_q ^ {56'd0, fold_byte};
  assign lo_prod   = fold_x * npf_pkg::PRIME_LO;
  assign fold_out  = (fold_x << npf_pkg::PRIME_SHIFT) + lo_prod[63:0];

  assign pend_inc  = (pend_q < npf_pkg::PEND_W'(npf_pkg::MAX_PATH_LEN)) ?
                     pend_q + npf_pkg::PEND_W'(1) : pend_q;
  assign pend_step = is_slash ? pend_inc : pend_q;
  assign seen_step = seen_q || is_char;
  assign hash_step = is_char ? fold_out : hash_q;
  // An all-slash path keeps exactly one slash.
  assign final_hash = (!seen_step && pend_step != '0) ? fold_out : hash_step;

  always_comb begin
    hash_d      = hash_q;
    pend_d      = pend_q;
    seen_d      = seen_q;
    out_hash_d  = out_hash_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    if (head_valid_i) begin
      if (flush_slash) begin
        hash_d = fold_out;
        pend_d = pend_q - npf_pkg::PEND_W'(1);
      end else if (!head_entry_i.last) begin
        pop_o  = 1'b1;
        hash_d = hash_step;
        pend_d = pend_step;
        seen_d = seen_step;
      end else if (out_free) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        out_hash_d  = final_hash;
        hash_d      = npf_pkg::FNV_BASIS;
        pend_d      = '0;
        seen_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= npf_pkg::FNV_BASIS;
      pend_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hash_q      <= hash_d;
      pend_q      <= pend_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hash_q <= out_hash_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

endmodule

@@ rtl/normalized_path_fnv1a64.sv @@
// ----------------------------------------------------------------------------
// normalized_path_fnv1a64: 64-bit FNV-1a hash of a normalized path
// Top level: input stage, entry queue and hashing engine.
// ----------------------------------------------------------------------------
// A path arrives one byte per input transaction and its 64-bit FNV-1a hash
// leaves as one output transaction on the transaction marked last. Bytes
// are normalized before hashing: a backslash becomes a slash and ASCII
// upper case becomes lower case. A run of slashes is held in a counter
// and hashed only when another byte follows, so trailing slashes drop out,
// while a path of nothing but slashes hashes as a single slash. A
// transaction with has_byte low and last high ends an empty path, whose
// hash is the offset basis; one with both low is ignored. Slash runs
// saturate at npf_pkg::MAX_PATH_LEN. The input stage takes one transaction
// per cycle, while the queue is not full, into a four-entry queue. The
// hashing engine spends one round of its single FNV round unit (a shift
// by 40 plus a 64 by 9 bit product) on each character entry, plus one
// round for each held slash that is folded in when a non-slash byte ends
// the run. Results sit in an output register, so the engine keeps working
// while a result waits, until a second result is due. The last byte
// passes through the input stage register and the queue to the engine,
// whose result is registered in the output register.
// ----------------------------------------------------------------------------
module normalized_path_fnv1a64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  path_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  // Front end to queue.
  logic            push;
  npf_pkg::entry_t push_entry;
  logic            queue_full;

  // Queue to back end.
  logic            head_valid;
  npf_pkg::entry_t head_entry;
  logic            pop;

  npf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .path_byte_i  (path_byte_i),
    .has_byte_i   (has_byte_i),
    .last_i       (last_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  npf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  // The engine pops an entry only once its work is complete; slash
  // flushes keep the entry at the head of the queue.
  npf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule

@@ rtl/npf_checker.sv @@
// ----------------------------------------------------------------------------
// npf_checker: port-level checks for the normalized path FNV-1a hasher
// Counts paths whose end was accepted but whose hash is not yet taken,
// checks the output against that count and checks the input hold rule.
// ----------------------------------------------------------------------------
module npf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  path_byte_i,
  input logic        has_byte_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] hash_value_o
);

  // Input stage and output register hold one path end each, the queue one per entry.
  localparam int unsigned Capacity = npf_pkg::QUEUE_DEPTH + 2;
  localparam int unsigned CntW     = $clog2(Capacity + 2);

  logic [CntW-1:0] open_q;
  logic            in_end, out_take;

  assign in_end   = in_valid_i && !in_stall_o && last_i;
  assign out_take = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_end && !out_take) begin
      open_q <= open_q + CntW'(1);
    end else if (out_take && !in_end) begin
      open_q <= open_q - CntW'(1);
    end
  end

  // A result is shown only for a path whose end was already accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> open_q != '0)
    else $error("result shown with no accepted path end");

  // The block never holds more path ends than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= CntW'(Capacity))
    else $error("more open paths than storage allows");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hash_value_o))
    else $error("stalled result changed or vanished");

  // A stalled input transaction keeps its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable({path_byte_i, has_byte_i, last_i}))
    else $error("stalled input transaction changed or vanished");

endmodule

bind normalized_path_fnv1a64 npf_checker u_npf_checker (.*);
